/* sv/rsbs_pkg.sv */
// Shared types and constants for the render-state batch splitter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package rsbs_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_STATE_ENABLE = 2'd1;
    localparam logic [1:0] REG_TO_SORTER    = 2'd2;

    localparam logic [16:0] VERTEX_COUNT_RST = 17'h10000;

    // state_enable bit positions
    localparam int EN_TEX0     = 0;
    localparam int EN_TEX1     = 1;
    localparam int EN_MATERIAL = 2;
    localparam int EN_SHADER   = 3;

    // result queue depth; a word raises at most two results
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = 2;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [16:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [15:0] vert_a;
        logic [15:0] vert_b;
        logic [15:0] vert_c;
        logic [15:0] tex0_handle;
        logic [15:0] tex1_handle;
        logic [15:0] material_handle;
        logic [15:0] shader_handle;
        logic        final_tri;
    } item_t;

    typedef struct packed {
        logic [17:0] first_index;
        logic [16:0] tri_total;
        logic [15:0] low_vertex;
        logic [16:0] vertex_span;
        logic [15:0] batch_tex0;
        logic [15:0] batch_tex1;
        logic [15:0] batch_material;
        logic [15:0] batch_shader;
        logic        sorted_dest;
        logic        run_end;
    } result_t;

    // results raised by one word; a lone result always travels in r0
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

/* sv/rsbs_core.sv */
// Batch tracking state and the per-word split logic of the batch splitter.
// Holds the configuration registers. Depends on rsbs_pkg.
`timescale 1ns / 1ps

module rsbs_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rsbs_pkg::cfg_wr_t cfg,
    input  logic             fire,
    input  rsbs_pkg::item_t  item,
    output rsbs_pkg::push_t  push
);

    localparam int VW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int EW = INDEX_BITS + 18;
    localparam int LIM_V = (INDEX_BITS >= 17) ? 131072 : (1 << INDEX_BITS);
    localparam logic [17:0] LIM = 18'(LIM_V);

    logic [16:0]           vertex_count_reg;
    logic [3:0]            state_enable_reg;
    logic                  to_sorter_reg;

    logic [INDEX_BITS-1:0] tri_counter_reg, tri_counter_next;
    logic [INDEX_BITS-1:0] batch_first_reg, batch_first_next;
    logic [16:0]           range_low_reg, range_low_next;
    logic [15:0]           range_high_reg, range_high_next;
    logic                  batch_open_reg, batch_open_next;
    logic [15:0]           held_reg [4];

    logic [15:0]           va, vb, vc, tmin, tmax;
    logic [17:0]           vc_nz, eff_vc;
    logic [16:0]           restart_low;
    logic [15:0]           cur [4];
    logic                  brk;
    logic [INDEX_BITS-1:0] base_first;
    logic [16:0]           base_low;
    logic [15:0]           base_high;
    logic [16:0]           new_low;
    logic [15:0]           new_high;
    rsbs_pkg::result_t     res_brk, res_fin;

    function automatic logic [15:0] mask_vert(input logic [15:0] v);
        logic [15:0] m;
        m = '0;
        m[VW-1:0] = v[VW-1:0];
        return m;
    endfunction

    function automatic logic [17:0] times3(input logic [INDEX_BITS-1:0] t);
        logic [17:0] f;
        f = 18'(EW'(t));
        return (f << 1) + f;
    endfunction

    function automatic logic [16:0] count17(input logic [INDEX_BITS-1:0] d);
        return 17'(EW'(d) + EW'(1));
    endfunction

    function automatic logic [16:0] span17(input logic [15:0] hi, input logic [16:0] lo);
        return {1'b0, hi} - lo + 17'd1;
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= rsbs_pkg::VERTEX_COUNT_RST;
            state_enable_reg <= '0;
            to_sorter_reg    <= 1'b0;
        end else if (cfg.we) begin
            unique case (cfg.index)
                rsbs_pkg::REG_VERTEX_COUNT: vertex_count_reg <= cfg.data;
                rsbs_pkg::REG_STATE_ENABLE: state_enable_reg <= cfg.data[3:0];
                rsbs_pkg::REG_TO_SORTER:    to_sorter_reg    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        va = mask_vert(item.vert_a);
        vb = mask_vert(item.vert_b);
        vc = mask_vert(item.vert_c);
        tmin = (va < vb) ? va : vb;
        if (vc < tmin) tmin = vc;
        tmax = (va > vb) ? va : vb;
        if (vc > tmax) tmax = vc;

        // zero counts as one; clamp to the index space
        vc_nz = (vertex_count_reg == 17'd0) ? 18'd1 : {1'b0, vertex_count_reg};
        eff_vc = (vc_nz > LIM) ? LIM : vc_nz;
        restart_low = 17'(eff_vc - 18'd1);

        cur[0] = item.tex0_handle;
        cur[1] = item.tex1_handle;
        cur[2] = item.material_handle;
        cur[3] = item.shader_handle;

        brk = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (state_enable_reg[k] && held_reg[k] != cur[k]) brk = 1'b1;
        end
        brk = brk && batch_open_reg;

        // batch closed at the previous triangle
        res_brk.first_index    = times3(batch_first_reg);
        res_brk.tri_total      = count17(tri_counter_reg - INDEX_BITS'(1) - batch_first_reg);
        res_brk.low_vertex     = range_low_reg[15:0];
        res_brk.vertex_span    = span17(range_high_reg, range_low_reg);
        res_brk.batch_tex0     = held_reg[rsbs_pkg::EN_TEX0];
        res_brk.batch_tex1     = held_reg[rsbs_pkg::EN_TEX1];
        res_brk.batch_material = held_reg[rsbs_pkg::EN_MATERIAL];
        res_brk.batch_shader   = held_reg[rsbs_pkg::EN_SHADER];
        res_brk.sorted_dest    = to_sorter_reg;
        res_brk.run_end        = !item.final_tri;

        if (!batch_open_reg || brk) begin
            base_first = tri_counter_reg;
            base_low   = restart_low;
            base_high  = '0;
        end else begin
            base_first = batch_first_reg;
            base_low   = range_low_reg;
            base_high  = range_high_reg;
        end
        new_low  = ({1'b0, tmin} < base_low) ? {1'b0, tmin} : base_low;
        new_high = (tmax > base_high) ? tmax : base_high;

        if (state_enable_reg == 4'd0) begin
            // whole mesh in one draw
            res_fin.first_index = '0;
            res_fin.tri_total   = count17(tri_counter_reg);
            res_fin.low_vertex  = '0;
            res_fin.vertex_span = eff_vc[16:0];
        end else begin
            res_fin.first_index = times3(base_first);
            res_fin.tri_total   = count17(tri_counter_reg - base_first);
            res_fin.low_vertex  = new_low[15:0];
            res_fin.vertex_span = span17(new_high, new_low);
        end
        res_fin.batch_tex0     = item.tex0_handle;
        res_fin.batch_tex1     = item.tex1_handle;
        res_fin.batch_material = item.material_handle;
        res_fin.batch_shader   = item.shader_handle;
        res_fin.sorted_dest    = to_sorter_reg;
        res_fin.run_end        = 1'b1;

        push.push0 = fire && (brk || item.final_tri);
        push.push1 = fire && brk && item.final_tri;
        push.r0    = brk ? res_brk : res_fin;
        push.r1    = res_fin;

        if (item.final_tri) begin
            tri_counter_next = '0;
            batch_first_next = '0;
            range_low_next   = restart_low;
            range_high_next  = '0;
            batch_open_next  = 1'b0;
        end else begin
            tri_counter_next = tri_counter_reg + INDEX_BITS'(1);
            batch_first_next = base_first;
            range_low_next   = new_low;
            range_high_next  = new_high;
            batch_open_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tri_counter_reg <= '0;
            batch_first_reg <= '0;
            range_low_reg   <= 17'(rsbs_pkg::VERTEX_COUNT_RST - 17'd1);
            range_high_reg  <= '0;
            batch_open_reg  <= 1'b0;
        end else if (fire) begin
            tri_counter_reg <= tri_counter_next;
            batch_first_reg <= batch_first_next;
            range_low_reg   <= range_low_next;
            range_high_reg  <= range_high_next;
            batch_open_reg  <= batch_open_next;
        end
    end

    // previous triangle's handles, no reset: only read once the pass has begun
    always_ff @(posedge aclk) begin
        if (fire) begin
            for (int k = 0; k < 4; k++) held_reg[k] <= cur[k];
        end
    end

    a_two_needs_final: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push1 |-> (push.push0 && item.final_tri))
        else $error("second result without a final triangle");

    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.final_tri) |=> (!batch_open_reg && tri_counter_reg == '0))
        else $error("pass not cleared after final triangle");

    a_break_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push0 && !item.final_tri) |-> (batch_open_reg && state_enable_reg != 4'd0))
        else $error("split reported outside an open batch");

    a_pass_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !item.final_tri) |=> batch_open_reg)
        else $error("batch not open after a triangle");

endmodule

/* sv/rsbs_resq.sv */
// Small result queue between the split logic and the result channel.
// Takes up to two results a cycle, hands out one while out_ready is high. Depends on rsbs_pkg.
`timescale 1ns / 1ps

module rsbs_resq (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsbs_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output rsbs_pkg::result_t out_data
);

    localparam int CW = rsbs_pkg::RESQ_AW + 1;

    rsbs_pkg::result_t          slot_reg [rsbs_pkg::RESQ_DEPTH];
    logic [rsbs_pkg::RESQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rsbs_pkg::RESQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         pop;
    logic [CW-1:0]                n_in;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // a word may need two slots
    assign room      = (count_reg <= CW'(rsbs_pkg::RESQ_DEPTH - 2));

    always_comb begin
        n_in        = CW'(push.push0) + CW'(push.push1);
        wr_ptr_next = wr_ptr_reg + n_in[rsbs_pkg::RESQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + rsbs_pkg::RESQ_AW'(pop);
        count_next  = count_reg + n_in - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push0) slot_reg[wr_ptr_reg] <= push.r0;
        if (push.push1) slot_reg[wr_ptr_reg + rsbs_pkg::RESQ_AW'(1)] <= push.r1;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rsbs_pkg::RESQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push0 |-> room)
        else $error("result pushed without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

/* sv/render_state_batch_splitter_top.sv */
// Top level of the render-state batch splitter: input word register,
// split logic (rsbs_core) and result queue (rsbs_resq). Depends on rsbs_pkg.
//
//   channel   dir  handshake            carries
//   s_*       in   s_valid / s_ready    one indexed triangle with its handles
//   m_*       out  m_valid / m_ready    one draw batch
//   cfg_*     in   cfg_we               register write, no read-back
//
// One triangle a cycle is taken when the result side keeps up; a triangle
// raising two batches does not hold up the input, the queue absorbs the extra.
// The input word register holds the triangle; its results wait in the queue.
// Synchronous active-low reset clears the pass state and the queue.
// s_ready drops only while the input register holds a word and the
// four-entry result queue has fewer than two free slots.
`timescale 1ns / 1ps

module render_state_batch_splitter_top #(
    parameter int INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_vert_a,
    input  logic [15:0] s_vert_b,
    input  logic [15:0] s_vert_c,
    input  logic [15:0] s_tex0_handle,
    input  logic [15:0] s_tex1_handle,
    input  logic [15:0] s_material_handle,
    input  logic [15:0] s_shader_handle,
    input  logic        s_final_tri,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [17:0] m_first_index,
    output logic [16:0] m_tri_total,
    output logic [15:0] m_low_vertex,
    output logic [16:0] m_vertex_span,
    output logic [15:0] m_batch_tex0,
    output logic [15:0] m_batch_tex1,
    output logic [15:0] m_batch_material,
    output logic [15:0] m_batch_shader,
    output logic        m_sorted_dest,
    output logic        m_run_end
);

    rsbs_pkg::item_t   in_word_reg;
    logic              in_vld_reg;
    logic              room;
    logic              fire;
    rsbs_pkg::cfg_wr_t cfg;
    rsbs_pkg::push_t   push;
    rsbs_pkg::result_t head;

    assign fire    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || fire;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg.vert_a          <= s_vert_a;
            in_word_reg.vert_b          <= s_vert_b;
            in_word_reg.vert_c          <= s_vert_c;
            in_word_reg.tex0_handle     <= s_tex0_handle;
            in_word_reg.tex1_handle     <= s_tex1_handle;
            in_word_reg.material_handle <= s_material_handle;
            in_word_reg.shader_handle   <= s_shader_handle;
            in_word_reg.final_tri       <= s_final_tri;
        end
    end

    rsbs_core #(
        .INDEX_BITS(INDEX_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (in_word_reg),
        .push    (push)
    );

    rsbs_resq u_resq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (head)
    );

    assign m_first_index    = head.first_index;
    assign m_tri_total      = head.tri_total;
    assign m_low_vertex     = head.low_vertex;
    assign m_vertex_span    = head.vertex_span;
    assign m_batch_tex0     = head.batch_tex0;
    assign m_batch_tex1     = head.batch_tex1;
    assign m_batch_material = head.batch_material;
    assign m_batch_shader   = head.batch_shader;
    assign m_sorted_dest    = head.sorted_dest;
    assign m_run_end        = head.run_end;

    a_fire_held_word: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> in_vld_reg)
        else $error("word processed without a held input");

    a_push_only_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        push.push0 |-> fire)
        else $error("result raised without a word");

    a_stall_holds_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !fire) |=> (in_vld_reg && $stable(in_word_reg)))
        else $error("held word lost while stalled");

endmodule
